/* hdl/assert_macros.svh */
// assertion macros used by the servo unit rtl file
// no dependencies; define ASSERT_OFF to compile the checks away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// check with reset masking
`define ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check that also runs through reset
`define ASSERT_NOW(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NOW(label, clk, prop, msg)
`endif
`endif

/* hdl/asps_pkg.sv */
// shared types, widths and distance table math for the averaged sensor pid servo
// no dependencies; used by the result and config interfaces, the top level and the testbench
package asps_pkg;

  // fixed field widths
  localparam int GAIN_W     = 16;
  localparam int CMP_W      = 16;
  localparam int LIM_W      = 20;
  localparam int ERR_W      = 21;
  localparam int ISUM_W     = 21;
  localparam int DIFF_W     = 22;
  localparam int PROD_W     = GAIN_W + DIFF_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // register defaults
  localparam logic [GAIN_W-1:0] KP_RESET     = 16'd5248;
  localparam logic [GAIN_W-1:0] KI_RESET     = 16'd205;
  localparam logic [GAIN_W-1:0] KD_RESET     = 16'd77;
  localparam logic [15:0]       TARGET_RESET = 16'd5632;
  localparam logic [CMP_W-1:0]  BASE_RESET   = 16'd2800;
  localparam logic [LIM_W-1:0]  ILIMIT_RESET = 20'd25600;
  localparam logic [CMP_W-1:0]  OMAX_RESET   = 16'd22999;

  // register indexes on the config channel
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP_GAIN = 3'd0,
    CFG_KI_GAIN = 3'd1,
    CFG_KD_GAIN = 3'd2,
    CFG_TARGET  = 3'd3,
    CFG_BASE    = 3'd4,
    CFG_ILIMIT  = 3'd5,
    CFG_OUT_MAX = 3'd6
  } cfg_index_t;

  // constants 2^(-2^-k) in q30, slot k
  typedef logic [30:0][63:0] root_tab_t;

  // floor integer square root, elaboration only
  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] bitv;
    x    = x_in;
    res  = 64'd0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bitv > x) bitv = bitv >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bitv != 64'd0) begin
        if (x >= res + bitv) begin
          x   = x - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    return res;
  endfunction

  // repeated square roots of one half in q30
  function automatic root_tab_t root_table();
    root_tab_t roots;
    roots    = '0;
    roots[1] = isqrt64(64'd1 << 59);
    for (int k = 2; k <= 30; k++) begin
      roots[k] = isqrt64(roots[k-1] << 30);
    end
    return roots;
  endfunction

  // distance 3600 * a^-1.046 in q.frac, average zero maps like average one
  function automatic logic [31:0] dist_entry(input int unsigned a_in,
                                             input int unsigned frac,
                                             input root_tab_t roots);
    logic [63:0] a;
    logic [63:0] m;
    logic [63:0] lg;
    logic [63:0] e;
    logic [63:0] r;
    logic [63:0] p;
    logic [63:0] num;
    int unsigned n;
    int unsigned q;
    a = (a_in == 0) ? 64'd1 : 64'(a_in);
    n = 0;
    for (int j = 0; j < 31; j++) begin
      if ((a >> (n + 1)) != 64'd0) n = n + 1;
    end
    // log2 by normalize and square
    m  = (a << 30) >> n;
    lg = 64'(n) << 30;
    for (int k = 1; k <= 30; k++) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m  = m >> 1;
        lg = lg | (64'd1 << (30 - k));
      end
    end
    e = (lg * 64'd1046 + 64'd500) / 64'd1000;
    q = 32'(e >> 30);
    r = e & ((64'd1 << 30) - 64'd1);
    // 2^-r from the root constants
    p = 64'd1 << 30;
    for (int k = 1; k <= 30; k++) begin
      if (r[30-k]) p = (p * roots[k] + (64'd1 << 29)) >> 30;
    end
    num = (64'd3600 << frac) * p + (64'd1 << (29 + q));
    return 32'(num >> (30 + q));
  endfunction

endpackage

/* hdl/asps_sample_if.sv */
// sample channel: one adc conversion per beat
// depends on nothing; width follows the adc resolution
interface asps_sample_if #(
  parameter int ADC_BITS = 10
) ();
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

/* hdl/asps_result_if.sv */
// result channel: servo compare value and distance error per beat
// depends on asps_pkg for field widths
interface asps_result_if ();
  logic                                 valid;
  logic                                 ready;
  logic [asps_pkg::CMP_W-1:0]           servo_compare;
  logic signed [asps_pkg::ERR_W-1:0]    distance_error;

  modport source (output valid, output servo_compare, output distance_error, input ready);
  modport sink (input valid, input servo_compare, input distance_error, output ready);
endinterface

/* hdl/asps_cfg_if.sv */
// config write channel: register index and write data per beat
// depends on asps_pkg for field widths
interface asps_cfg_if ();
  logic                            valid;
  logic                            ready;
  logic [asps_pkg::CFG_IDX_W-1:0]  index;
  logic [asps_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* hdl/averaged_sensor_pid_servo_unit.sv */
// Averaged sensor PID servo. Takes one ADC sample per beat, every cycle unless
// table fill or a stalled result holds it off. Every SAMPLES_PER_UPDATE-th
// sample closes an average, which looks up a distance in a table RAM, and the
// PID update emits one result beat once that sample has passed the pipeline;
// other samples give no result. The pipeline has eight register stages, one a
// table read, so a new sample can enter each cycle while results stream out; a
// stalled result holds the whole pipeline. After reset the table RAM is filled
// from the elaborated distance table, one entry a cycle, all 2^ADC_BITS of them
// (1024 by default); samples are not taken until it is done, config writes are.
// depends on asps_pkg, the channel interfaces, asps_ram and assert_macros.svh
`include "assert_macros.svh"

module averaged_sensor_pid_servo_unit #(
  parameter int SAMPLES_PER_UPDATE = 6,
  parameter int ADC_BITS           = 10,
  parameter int FRAC_BITS          = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  asps_sample_if.sink           samples,
  asps_result_if.source         results,
  asps_cfg_if.sink              cfg
);

  localparam int SUM_W    = ADC_BITS + $clog2(SAMPLES_PER_UPDATE);
  localparam int CNT_W    = (SAMPLES_PER_UPDATE > 1) ? $clog2(SAMPLES_PER_UPDATE) : 1;
  localparam int RECIP_SH = SUM_W;
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam int RECIP   = (1 << RECIP_SH) / SAMPLES_PER_UPDATE;
  localparam int QP_W     = SUM_W + RECIP_W;
  localparam int DEPTH    = 1 << ADC_BITS;
  localparam int ROM_W    = 12 + FRAC_BITS;
  localparam int ERRW_W   = (ROM_W + 2 > 22) ? ROM_W + 2 : 22;
  localparam int SHIFT    = 8 + FRAC_BITS;
  localparam int TERM_W   = asps_pkg::PROD_W - SHIFT;
  localparam int TOT_W    = TERM_W + 2;
  localparam int LIMS_W   = asps_pkg::ISUM_W + 1;

  localparam logic signed [ERRW_W-1:0] ERR_HI = ERRW_W'((1 << (asps_pkg::ERR_W - 1)) - 1);
  localparam logic signed [ERRW_W-1:0] ERR_LO = ERRW_W'(-(1 << (asps_pkg::ERR_W - 1)));

  typedef logic [DEPTH-1:0][ROM_W-1:0] dist_table_t;

  // distance table worked out at elaboration
  function automatic dist_table_t build_table();
    dist_table_t tbl;
    asps_pkg::root_tab_t roots;
    roots = asps_pkg::root_table();
    for (int a = 0; a < DEPTH; a++) begin
      tbl[a] = ROM_W'(asps_pkg::dist_entry(32'(a), 32'(FRAC_BITS), roots));
    end
    return tbl;
  endfunction

  localparam dist_table_t DIST_TABLE = build_table();

  // config registers
  logic [asps_pkg::GAIN_W-1:0] kp_gain;
  logic [asps_pkg::GAIN_W-1:0] ki_gain;
  logic [asps_pkg::GAIN_W-1:0] kd_gain;
  logic [15:0]                 target_distance;
  logic [asps_pkg::CMP_W-1:0]  base_offset;
  logic [asps_pkg::LIM_W-1:0]  integral_limit;
  logic [asps_pkg::CMP_W-1:0]  output_max;

  // table fill
  logic                filling;
  logic [ADC_BITS-1:0] fill_addr;

  // averaging
  logic                accept;
  logic                last_sample;
  logic [SUM_W-1:0]    sample_sum;
  logic [SUM_W-1:0]    sum_next;
  logic [CNT_W-1:0]    sample_count;

  // pipeline control
  logic pipe_en;
  logic v1, v2, v3, v4, v5, v6, v7;
  logic out_valid;

  // pipeline payload
  logic [SUM_W-1:0]                    sum1, sum2;
  logic [QP_W-1:0]                     quot_prod;
  logic [ADC_BITS-1:0]                 q_est, q2, avg;
  logic [SUM_W-1:0]                    rem;
  logic [ROM_W-1:0]                    dist_mm;
  logic signed [ERRW_W-1:0]            err_wide;
  logic signed [asps_pkg::ERR_W-1:0]   err3, err4, err5, err6, err7;
  logic signed [asps_pkg::ISUM_W-1:0]  error_sum;
  logic signed [asps_pkg::ERR_W-1:0]   last_error;
  logic signed [LIMS_W-1:0]            lim_s;
  logic signed [LIMS_W-1:0]            isum_raw;
  logic signed [asps_pkg::ISUM_W-1:0]  isum_next, isum5;
  logic signed [asps_pkg::DIFF_W-1:0]  diff_next, diff5;
  logic signed [asps_pkg::PROD_W-1:0]  p_prod, i_prod, d_prod, p6, i6, d6;
  logic signed [TOT_W-1:0]             total, tot7;
  logic [asps_pkg::CMP_W-1:0]          servo_sat;
  logic [asps_pkg::CMP_W-1:0]          servo_compare;
  logic signed [asps_pkg::ERR_W-1:0]   distance_error;

  // config write port, always ready
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain         <= asps_pkg::KP_RESET;
      ki_gain         <= asps_pkg::KI_RESET;
      kd_gain         <= asps_pkg::KD_RESET;
      target_distance <= asps_pkg::TARGET_RESET;
      base_offset     <= asps_pkg::BASE_RESET;
      integral_limit  <= asps_pkg::ILIMIT_RESET;
      output_max      <= asps_pkg::OMAX_RESET;
    end else if (cfg.valid) begin
      case (asps_pkg::cfg_index_t'(cfg.index))
        asps_pkg::CFG_KP_GAIN: kp_gain         <= cfg.data[asps_pkg::GAIN_W-1:0];
        asps_pkg::CFG_KI_GAIN: ki_gain         <= cfg.data[asps_pkg::GAIN_W-1:0];
        asps_pkg::CFG_KD_GAIN: kd_gain         <= cfg.data[asps_pkg::GAIN_W-1:0];
        asps_pkg::CFG_TARGET:  target_distance <= cfg.data[15:0];
        asps_pkg::CFG_BASE:    base_offset     <= cfg.data[asps_pkg::CMP_W-1:0];
        asps_pkg::CFG_ILIMIT:  integral_limit  <= cfg.data[asps_pkg::LIM_W-1:0];
        asps_pkg::CFG_OUT_MAX: output_max      <= cfg.data[asps_pkg::CMP_W-1:0];
        default: ;
      endcase
    end
  end

  // table ram fill sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      filling   <= 1'b1;
      fill_addr <= '0;
    end else if (filling) begin
      if (fill_addr == '1) filling <= 1'b0;
      fill_addr <= fill_addr + ADC_BITS'(1);
    end
  end

  // whole pipeline moves unless a result is stuck
  assign pipe_en       = !out_valid || results.ready;
  assign samples.ready = !filling && pipe_en;
  assign accept        = samples.valid && samples.ready;

  // running sum of samples
  assign sum_next    = sample_sum + SUM_W'(samples.sample);
  assign last_sample = (sample_count == CNT_W'(SAMPLES_PER_UPDATE - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum   <= '0;
      sample_count <= '0;
    end else if (accept) begin
      if (last_sample) begin
        sample_sum   <= '0;
        sample_count <= '0;
      end else begin
        sample_sum   <= sum_next;
        sample_count <= sample_count + CNT_W'(1);
      end
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      out_valid <= 1'b0;
    end else if (pipe_en) begin
      v1 <= accept && last_sample;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      out_valid <= v7;
    end
  end

  // average estimate by reciprocal multiply
  assign quot_prod = QP_W'(sum1) * QP_W'(RECIP);
  assign q_est     = quot_prod[RECIP_SH +: ADC_BITS];

  // one step correction of the estimate
  assign rem = sum2 - SUM_W'(q2) * SUM_W'(SAMPLES_PER_UPDATE);
  assign avg = q2 + ADC_BITS'(rem >= SUM_W'(SAMPLES_PER_UPDATE));

  asps_ram #(
    .WIDTH (ROM_W),
    .DEPTH (DEPTH)
  ) u_dist_ram (
    .clk   (clk),
    .we    (filling),
    .waddr (fill_addr),
    .wdata (DIST_TABLE[fill_addr]),
    .re    (pipe_en),
    .raddr (avg),
    .rdata (dist_mm)
  );

  // error against setpoint, saturated to the field range
  assign err_wide = $signed({{(ERRW_W - 16){1'b0}}, target_distance})
                  - $signed({{(ERRW_W - ROM_W){1'b0}}, dist_mm});

  always_comb begin
    if (err_wide > ERR_HI) begin
      err3 = asps_pkg::ERR_W'(ERR_HI);
    end else if (err_wide < ERR_LO) begin
      err3 = asps_pkg::ERR_W'(ERR_LO);
    end else begin
      err3 = asps_pkg::ERR_W'(err_wide);
    end
  end

  // integral with symmetric clamp, and derivative difference
  assign lim_s     = $signed({{(LIMS_W - asps_pkg::LIM_W){1'b0}}, integral_limit});
  assign isum_raw  = error_sum + err4;
  assign diff_next = err4 - last_error;

  always_comb begin
    if (isum_raw > lim_s) begin
      isum_next = asps_pkg::ISUM_W'(lim_s);
    end else if (isum_raw < -lim_s) begin
      isum_next = asps_pkg::ISUM_W'(-lim_s);
    end else begin
      isum_next = asps_pkg::ISUM_W'(isum_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum  <= '0;
      last_error <= '0;
    end else if (pipe_en && v4) begin
      error_sum  <= isum_next;
      last_error <= err4;
    end
  end

  // gain products
  assign p_prod = $signed({1'b0, kp_gain}) * err5;
  assign i_prod = $signed({1'b0, ki_gain}) * isum5;
  assign d_prod = $signed({1'b0, kd_gain}) * diff5;

  // floor shift of each term, then offset
  assign total = $signed(p6[asps_pkg::PROD_W-1:SHIFT])
               + $signed(i6[asps_pkg::PROD_W-1:SHIFT])
               + $signed(d6[asps_pkg::PROD_W-1:SHIFT])
               + $signed({{(TOT_W - asps_pkg::CMP_W){1'b0}}, base_offset});

  // output saturation to 0 .. output_max
  always_comb begin
    if (tot7 < 0) begin
      servo_sat = '0;
    end else if (tot7 > $signed({{(TOT_W - asps_pkg::CMP_W){1'b0}}, output_max})) begin
      servo_sat = output_max;
    end else begin
      servo_sat = tot7[asps_pkg::CMP_W-1:0];
    end
  end

  // stage payload registers
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sum1  <= sum_next;
      sum2  <= sum1;
      q2    <= q_est;
      err4  <= err3;
      err5  <= err4;
      isum5 <= isum_next;
      diff5 <= diff_next;
      err6  <= err5;
      p6    <= p_prod;
      i6    <= i_prod;
      d6    <= d_prod;
      err7  <= err6;
      tot7  <= total;
      if (v7) begin
        servo_compare  <= servo_sat;
        distance_error <= err7;
      end
    end
  end

  assign results.valid          = out_valid;
  assign results.servo_compare  = servo_compare;
  assign results.distance_error = distance_error;

  // checks
  `ASSERT_NOW(a_reset_state, clk, rst |=> (filling && !out_valid), "reset left pipeline busy")
  `ASSERT_PROP(a_fill_quiet, clk, rst, filling |-> !(v1 || v2 || v3 || v4 || v5 || v6 || v7 || out_valid), "beat in flight during table fill")
  `ASSERT_PROP(a_isum_clamp, clk, rst, (pipe_en && v4) |=> (error_sum <= $past(lim_s) && error_sum >= -$past(lim_s)), "integral outside clamp")
  `ASSERT_PROP(a_out_max, clk, rst, (pipe_en && v7) |=> (results.servo_compare <= $past(output_max)), "compare above output max")

endmodule

/* hdl/asps_ram.sv */
// generic single write port ram with registered read
// no dependencies
module asps_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

/* sim/asps_servo_checker.sv */
// checker for the averaged sensor pid servo: watches the sample, result and config channels,
// predicts every servo beat and compares it field by field
// depends on asps_pkg and the three channel interfaces
module asps_servo_checker (
  input  logic   clk,
  input  logic   rst,
  asps_sample_if samples,
  asps_result_if results,
  asps_cfg_if    cfg,
  output int     fail_count,
  output int     outstanding,
  output int     samples_seen,
  output int     updates_seen,
  output int     windup_hits,
  output int     floor_hits,
  output int     ceiling_hits
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          UPDATE_EVERY  = 6;
  localparam int          TABLE_DEPTH   = 1024;
  localparam int          Q_FRAC        = 8;
  localparam int          TERM_SHIFT    = 8 + Q_FRAC;
  localparam int          LOG_BITS      = 30;
  localparam int unsigned DIST_SCALE_MM = 3600;
  localparam int unsigned EXP_NUM       = 1046;
  localparam int unsigned EXP_DEN       = 1000;
  localparam longint      ERR_HI        = 1048575;
  localparam longint      ERR_LO        = -1048576;
  localparam int          SHOWN_FAILS   = 40;

  typedef struct packed {
    logic [asps_pkg::CMP_W-1:0] compare;
    logic [asps_pkg::ERR_W-1:0] error;
  } servo_beat_t;

  // distance table in q.8, built once at time zero
  logic [31:0] dist_mm [TABLE_DEPTH];

  // register copy
  logic [asps_pkg::GAIN_W-1:0] kp, ki, kd;
  logic [15:0]                 target_mm;
  logic [asps_pkg::CMP_W-1:0]  base_cmp, out_max;
  logic [asps_pkg::LIM_W-1:0]  int_limit;

  // averaging and pid state
  logic [12:0]  acc_sum;
  logic [2:0]   acc_count;
  longint       err_integral;
  longint       err_prev;
  servo_beat_t  servo_beats_due [$];

  // floor square root, bit by bit from the top
  function automatic longint unsigned sqrt_floor(input longint unsigned x);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) root = trial;
    end
    return root;
  endfunction

  // 3600 * a^-1.046 in fixed point: log2 by squaring, then 2^-frac from root constants
  initial begin : build_dist
    longint unsigned half_roots [31];
    longint unsigned mant, lg, expo, expo_frac, pw;
    int unsigned     msb, q;
    half_roots[0] = 0;
    half_roots[1] = sqrt_floor(64'd1 << 59);
    for (int k = 2; k <= LOG_BITS; k++) half_roots[k] = sqrt_floor(half_roots[k-1] << LOG_BITS);
    for (int a = 1; a < TABLE_DEPTH; a++) begin
      msb = 0;
      for (int b = 0; b < 10; b++) if (((a >> b) & 1) != 0) msb = b;
      mant = (64'(a) << LOG_BITS) >> msb;
      lg   = 64'(msb) << LOG_BITS;
      for (int k = 1; k <= LOG_BITS; k++) begin
        mant = (mant * mant) >> LOG_BITS;
        if (mant >= (64'd2 << LOG_BITS)) begin
          mant = mant >> 1;
          lg   = lg | (64'd1 << (LOG_BITS - k));
        end
      end
      expo      = (lg * EXP_NUM + EXP_DEN / 2) / EXP_DEN;
      q         = int'(expo >> LOG_BITS);
      expo_frac = expo & ((64'd1 << LOG_BITS) - 1);
      pw        = 64'd1 << LOG_BITS;
      for (int k = 1; k <= LOG_BITS; k++) begin
        if (((expo_frac >> (LOG_BITS - k)) & 1) != 0)
          pw = (pw * half_roots[k] + (64'd1 << (LOG_BITS - 1))) >> LOG_BITS;
      end
      dist_mm[a] = 32'(((64'(DIST_SCALE_MM) << Q_FRAC) * pw + (64'd1 << (LOG_BITS - 1 + q)))
                        >> (LOG_BITS + q));
    end
    // average zero reads like average one
    dist_mm[0] = dist_mm[1];
  end

  task automatic report(input string msg);
    if (fail_count < SHOWN_FAILS) $display("[%0t] servo check: %s", $time, msg);
    fail_count++;
  endtask

  // one sample beat; every sixth closes an average and yields a servo beat
  task automatic predict_servo_beat(input logic [9:0] s);
    logic [9:0]  avg;
    longint      err, acc, lim, p_term, i_term, d_term, total;
    servo_beat_t beat;
    acc_sum   = acc_sum + 13'(s);
    acc_count = acc_count + 3'd1;
    if (acc_count == 3'(UPDATE_EVERY)) begin
      avg       = 10'(acc_sum / 13'(UPDATE_EVERY));
      acc_sum   = '0;
      acc_count = '0;
      err = longint'(target_mm) - longint'(dist_mm[avg]);
      if (err > ERR_HI) err = ERR_HI;
      if (err < ERR_LO) err = ERR_LO;
      // integral with symmetric clamp
      lim = longint'(int_limit);
      acc = err_integral + err;
      if (acc > lim || acc < -lim) windup_hits++;
      if (acc > lim) acc = lim;
      if (acc < -lim) acc = -lim;
      err_integral = acc;
      // q8.8 gain terms, floor shift
      p_term = (longint'(kp) * err) >>> TERM_SHIFT;
      i_term = (longint'(ki) * err_integral) >>> TERM_SHIFT;
      d_term = (longint'(kd) * (err - err_prev)) >>> TERM_SHIFT;
      err_prev = err;
      total = p_term + i_term + d_term + longint'(base_cmp);
      if (total < 0) begin
        total = 0;
        floor_hits++;
      end
      if (total > longint'(out_max)) begin
        total = longint'(out_max);
        ceiling_hits++;
      end
      beat.compare = total[asps_pkg::CMP_W-1:0];
      beat.error   = err[asps_pkg::ERR_W-1:0];
      servo_beats_due.push_back(beat);
    end
  endtask

  initial begin
    fail_count   = 0;
    samples_seen = 0;
    updates_seen = 0;
    windup_hits  = 0;
    floor_hits   = 0;
    ceiling_hits = 0;
    outstanding  = 0;
  end

  always @(posedge clk) begin
    servo_beat_t due;
    if (rst) begin
      kp           = asps_pkg::KP_RESET;
      ki           = asps_pkg::KI_RESET;
      kd           = asps_pkg::KD_RESET;
      target_mm    = asps_pkg::TARGET_RESET;
      base_cmp     = asps_pkg::BASE_RESET;
      int_limit    = asps_pkg::ILIMIT_RESET;
      out_max      = asps_pkg::OMAX_RESET;
      acc_sum      = '0;
      acc_count    = '0;
      err_integral = 0;
      err_prev     = 0;
      servo_beats_due.delete();
    end else begin
      // result beat against the oldest prediction
      if (results.valid && results.ready) begin
        if (servo_beats_due.size() == 0) begin
          report($sformatf("unexpected beat compare %0d error %0d",
                           results.servo_compare, results.distance_error));
        end else begin
          due = servo_beats_due.pop_front();
          updates_seen++;
          if (results.servo_compare !== due.compare)
            report($sformatf("servo_compare got %0d want %0d",
                             results.servo_compare, due.compare));
          if (results.distance_error !== due.error)
            report($sformatf("distance_error got %0d want %0d",
                             results.distance_error, $signed(due.error)));
        end
      end
      // register write
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          asps_pkg::CFG_KP_GAIN: kp        = cfg.data[asps_pkg::GAIN_W-1:0];
          asps_pkg::CFG_KI_GAIN: ki        = cfg.data[asps_pkg::GAIN_W-1:0];
          asps_pkg::CFG_KD_GAIN: kd        = cfg.data[asps_pkg::GAIN_W-1:0];
          asps_pkg::CFG_TARGET:  target_mm = cfg.data[15:0];
          asps_pkg::CFG_BASE:    base_cmp  = cfg.data[asps_pkg::CMP_W-1:0];
          asps_pkg::CFG_ILIMIT:  int_limit = cfg.data[asps_pkg::LIM_W-1:0];
          asps_pkg::CFG_OUT_MAX: out_max   = cfg.data[asps_pkg::CMP_W-1:0];
          default: ;
        endcase
      end
      // sample beat
      if (samples.valid && samples.ready) begin
        samples_seen++;
        predict_servo_beat(samples.sample);
      end
    end
    outstanding <= servo_beats_due.size();
  end

endmodule

/* sim/tb.sv */
// top of the averaged sensor pid servo testbench: clock, reset, sample and config stimulus,
// result back-pressure and the verdict
// depends on asps_pkg, the channel interfaces, the block and asps_servo_checker
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES  = 250000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int MAX_GAP       = 16;
  localparam int N_PHASES      = 9;
  localparam logic [asps_pkg::CFG_IDX_W-1:0]  CFG_SPARE = 3'd7;  // index past the register list
  localparam logic [asps_pkg::CFG_DATA_W-1:0] ALL_ONES  = 20'hFFFFF;

  typedef enum int {MIX_UNIFORM, MIX_LEVEL, MIX_LOW, MIX_RAILS} sample_mix_t;

  logic clk;
  logic rst;
  bit   eager;
  int   hold_asked;
  int   hold_served;
  int   cycle_count;
  int   reg_writes;
  int   settings_used;

  int fail_count, outstanding, samples_seen, updates_seen;
  int windup_hits, floor_hits, ceiling_hits;

  asps_sample_if #(.ADC_BITS(10)) samples ();
  asps_result_if                  results ();
  asps_cfg_if                     cfg ();

  averaged_sensor_pid_servo_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .results (results),
    .cfg     (cfg)
  );

  asps_servo_checker i_check (
    .clk          (clk),
    .rst          (rst),
    .samples      (samples),
    .results      (results),
    .cfg          (cfg),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .samples_seen (samples_seen),
    .updates_seen (updates_seen),
    .windup_hits  (windup_hits),
    .floor_hits   (floor_hits),
    .ceiling_hits (ceiling_hits)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("run limit of %0d cycles reached, %0d servo beats still due",
               LIMIT_CYCLES, outstanding);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int draw_gap();
    return eager ? 0 : int'($urandom_range(MAX_GAP));
  endfunction

  // result side: random stalls per beat, plus one long hold-off on request
  initial begin : result_drain
    int gap;
    results.ready <= 1'b0;
    hold_served = 0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_served != hold_asked) begin
        hold_served++;
        results.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = draw_gap();
      if (gap > 0) begin
        results.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      results.ready <= 1'b1;
      do @(posedge clk); while (!results.valid);
    end
  end

  // one sample beat, valid kept high across back-to-back beats
  task automatic send_sample(input logic [9:0] value);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      samples.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples.valid  <= 1'b1;
    samples.sample <= value;
    do @(posedge clk); while (!samples.ready);
  endtask

  task automatic write_reg(input logic [asps_pkg::CFG_IDX_W-1:0] idx,
                           input logic [asps_pkg::CFG_DATA_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  task automatic write_all(input logic [asps_pkg::CFG_DATA_W-1:0] kp, ki, kd, tgt, base, lim,
                           omax);
    write_reg(asps_pkg::CFG_KP_GAIN, kp);
    write_reg(asps_pkg::CFG_KI_GAIN, ki);
    write_reg(asps_pkg::CFG_KD_GAIN, kd);
    write_reg(asps_pkg::CFG_TARGET, tgt);
    write_reg(asps_pkg::CFG_BASE, base);
    write_reg(asps_pkg::CFG_ILIMIT, lim);
    write_reg(asps_pkg::CFG_OUT_MAX, omax);
    settings_used++;
  endtask

  // wait until every servo beat is in, with the sample channel idle
  task automatic settle();
    samples.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [asps_pkg::CFG_DATA_W-1:0] reg_pick();
    case ($urandom_range(3))
      0:       return 20'($urandom);
      1:       return 20'($urandom_range(65535));
      default: return 20'($urandom_range(4095));
    endcase
  endfunction

  // groups of six share a mix, some around a level, so averages spread over the whole table
  task automatic random_samples(input int count, input bit with_hold);
    sample_mix_t mix;
    int          level;
    int          v;
    mix   = MIX_UNIFORM;
    level = 0;
    for (int k = 0; k < count; k++) begin
      if (k % 6 == 0) begin
        mix   = sample_mix_t'($urandom_range(3));
        level = (mix == MIX_LOW) ? int'($urandom_range(24)) : int'($urandom_range(1023));
      end
      if (with_hold && k == 30) hold_asked++;
      case (mix)
        MIX_UNIFORM: v = int'($urandom_range(1023));
        MIX_RAILS:   v = ($urandom_range(1) != 0) ? 1023 : 0;
        default:     v = level + int'($urandom_range(16)) - 8;
      endcase
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      send_sample(v[9:0]);
    end
  endtask

  initial begin : stimulus
    rst            <= 1'b1;
    samples.valid  <= 1'b0;
    samples.sample <= '0;
    cfg.valid      <= 1'b0;
    cfg.index      <= '0;
    cfg.data       <= '0;
    eager          = 1'b0;
    hold_asked     = 0;
    reg_writes     = 0;
    settings_used  = 1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed, reset settings: average zero first with no previous error,
    // then full scale, average one (deep negative error, integral clamp, floor)
    repeat (6) send_sample(10'd0);
    repeat (6) send_sample(10'd1023);
    repeat (6) send_sample(10'd1);
    repeat (3) begin
      send_sample(10'h2AA);
      send_sample(10'h155);
    end
    random_samples(150, 1'b0);

    for (int ph = 1; ph < N_PHASES; ph++) begin
      settle();
      case (ph)
        // every register at its top, upper data bits dropped where narrower
        1: write_all(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
        // everything zero, including a zero integral limit and output ceiling
        2: write_all('0, '0, '0, '0, '0, '0, '0);
        // back to reset values with a low ceiling
        3: write_all(asps_pkg::CFG_DATA_W'(asps_pkg::KP_RESET),
                     asps_pkg::CFG_DATA_W'(asps_pkg::KI_RESET),
                     asps_pkg::CFG_DATA_W'(asps_pkg::KD_RESET),
                     asps_pkg::CFG_DATA_W'(asps_pkg::TARGET_RESET),
                     asps_pkg::CFG_DATA_W'(asps_pkg::BASE_RESET),
                     asps_pkg::CFG_DATA_W'(asps_pkg::ILIMIT_RESET), 20'd4000);
        default: begin
          write_all(reg_pick(), reg_pick(), reg_pick(), reg_pick(), reg_pick(),
                    reg_pick(), reg_pick());
          if (ph == 6) write_reg(CFG_SPARE, 20'($urandom));
        end
      endcase
      eager = (ph == 2 || ph == 5);
      random_samples((ph == 3) ? 250 : 180, ph == 3);
    end

    settle();
    $display("sent %0d samples, checked %0d servo beats over %0d settings (%0d register writes)",
             samples_seen, updates_seen, settings_used, reg_writes);
    $display("integral clamp taken %0d times, compare floored %0d, capped %0d",
             windup_hits, floor_hits, ceiling_hits);
    if (outstanding != 0) $display("%0d servo beats never arrived", outstanding);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/asps_pkg.sv
hdl/asps_sample_if.sv
hdl/asps_result_if.sv
hdl/asps_cfg_if.sv
hdl/asps_ram.sv
hdl/averaged_sensor_pid_servo_unit.sv
sim/asps_servo_checker.sv
sim/tb.sv
